@@ design/etmg_pkg.sv @@
// Shared constants and table-building functions for the exposure tone map.
// No dependencies; imported by the exp2 and log2 units and the channel path.
`timescale 1ns / 1ps
`default_nettype none
package etmg_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_EXPOSURE  = 2'd0;
  localparam logic [1:0] REG_INV_GAMMA = 2'd1;

  localparam logic [15:0] EXPOSURE_RST  = 16'd256;
  localparam logic [15:0] INV_GAMMA_RST = 16'd7447;

  // log2(e) in Q1.30
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  // Width of the Q.16 exponent fed to the exp2 unit
  localparam int unsigned EXP_TW = 23;

  function automatic longint unsigned isqrt64(input longint unsigned v_in);
    longint unsigned v;
    longint unsigned res;
    longint unsigned bt;
    v = v_in;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // 2^(k/2^ab) in Q2.30
  function automatic logic [31:0] exp2_node(input int unsigned k, input int unsigned ab);
    longint unsigned acc;
    longint unsigned root;
    int unsigned d;
    acc = ONE_Q30;
    root = 2 * ONE_Q30;
    if (k >= (32'd1 << ab)) return 32'(2 * ONE_Q30);
    for (d = 1; d <= ab; d++) begin
      root = isqrt64(root << 30);
      if (((k >> (ab - d)) & 1) != 0) acc = (acc * root + (64'd1 << 29)) >> 30;
    end
    return 32'(acc);
  endfunction

  // log2(1 + k/2^ab) in Q1.30
  function automatic logic [30:0] log2_node(input int unsigned k, input int unsigned ab);
    longint unsigned z;
    longint unsigned res;
    int unsigned i;
    res = 0;
    if (k >= (32'd1 << ab)) return 31'(ONE_Q30);
    z = ONE_Q30 + (longint'(k) << (30 - ab));
    for (i = 1; i <= 30; i++) begin
      z = (z * z) >> 30;
      if (z >= 2 * ONE_Q30) begin
        z = z >> 1;
        res = res | (64'd1 << (30 - i));
      end
    end
    return 31'(res);
  endfunction

endpackage
`default_nettype wire

@@ design/exposure_tone_map_gamma.sv @@
// Top level: stream handshake, stage valid chain, config registers, and
// three channel pipelines. Depends on etmg_pkg and etmg_channel.
//
//  channel   direction  handshake                   payload
//  s_axis    in         s_axis_tvalid/tready        tdata red,green,blue; tlast frame end
//  m_axis    out        m_axis_tvalid/tready        tdata red,green,blue; tlast frame end
//  cfg       in         cfg_valid_i/cfg_ready_o     cfg_index_i, cfg_data_i
//
// One pixel per clock sustained while the output is not stalled; nine stages.
// Each stage has its own valid bit and loads when empty or when the next
// stage moves, so bubbles close up and input keeps flowing while a result waits.
// Reset clears valid bits and loads exposure 1.0 and inverse gamma about 1/2.2.
`timescale 1ns / 1ps
`default_nettype none
module exposure_tone_map_gamma import etmg_pkg::*; #(
  parameter int unsigned TABLE_ADDR_BITS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [95:0] s_axis_tdata,  // red_in, green_in, blue_in
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [47:0] m_axis_tdata,  // red_out, green_out, blue_out
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);
  // Configuration registers
  logic [15:0] exposure_q, inv_gamma_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exposure_q  <= EXPOSURE_RST;
      inv_gamma_q <= INV_GAMMA_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_EXPOSURE:  exposure_q  <= cfg_data_i;
        REG_INV_GAMMA: inv_gamma_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage ready chain: a stage loads when empty or when its successor moves
  logic [9:1]  v_q;
  logic [10:1] rdy;
  assign rdy[10] = m_axis_tready;
  for (genvar gs = 1; gs <= 9; gs++) begin : g_rdy
    assign rdy[gs] = !v_q[gs] || rdy[gs+1];
  end
  assign s_axis_tready = rdy[1];

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[1]) v_q[1] <= s_axis_tvalid;
      for (int i = 2; i <= 9; i++) begin
        if (rdy[i]) v_q[i] <= v_q[i-1];
      end
    end
  end

  // Carry the frame flag with the item
  logic [9:1] last_q;
  always_ff @(posedge clk_i) begin
    if (rdy[1]) last_q[1] <= s_axis_tlast;
    for (int i = 2; i <= 9; i++) begin
      if (rdy[i]) last_q[i] <= last_q[i-1];
    end
  end

  for (genvar gc = 0; gc < 3; gc++) begin : g_ch
    etmg_channel #(.TABLE_ADDR_BITS(TABLE_ADDR_BITS)) u_ch (
      .clk_i,
      .en_i        (rdy[9:1]),
      .exposure_i  (exposure_q),
      .inv_gamma_i (inv_gamma_q),
      .v_i         (s_axis_tdata[32*gc +: 32]),
      .out_o       (m_axis_tdata[16*gc +: 16])
    );
  end

  assign m_axis_tvalid = v_q[9];
  assign m_axis_tlast  = last_q[9];
endmodule
`default_nettype wire

@@ design/etmg_exp2.sv @@
// Two-stage 2^-t unit: table lookup and slope product, then interpolate, shift and round.
// Depends on etmg_pkg for the table function.
`timescale 1ns / 1ps
`default_nettype none
module etmg_exp2 import etmg_pkg::*; #(
  parameter int unsigned TABLE_ADDR_BITS = 8
) (
  input  wire logic              clk_i,
  input  wire logic              en_a_i,
  input  wire logic              en_b_i,
  input  wire logic [EXP_TW-1:0] t_i,
  output logic      [17:0]       em_o
);
  localparam int unsigned N  = 1 << TABLE_ADDR_BITS;
  localparam int unsigned SH = 16 - TABLE_ADDR_BITS;

  logic [31:0] tab [N+1];
  for (genvar gk = 0; gk <= N; gk++) begin : g_tab
    assign tab[gk] = exp2_node(gk, TABLE_ADDR_BITS);
  end

  // Stage A: split exponent, look up neighbors, form slope product
  logic [15:0] fp, f;
  logic [6:0]  ip;
  logic        fpz;
  logic [TABLE_ADDR_BITS:0] kk;
  logic [31:0] na, nb;
  logic [SH-1:0] r;
  logic [7:0]  s;

  assign ip  = 7'(t_i[EXP_TW-1:16]);
  assign fp  = t_i[15:0];
  assign fpz = (fp == 16'd0);
  assign f   = 16'(17'h10000 - {1'b0, fp});
  assign kk  = {1'b0, f[15:SH]};
  assign r   = f[SH-1:0];
  assign na  = tab[kk];
  assign nb  = tab[kk + 1'b1];
  assign s   = fpz ? {1'b0, ip} : ({1'b0, ip} + 8'd1);

  logic [31:0]      a_q;
  logic [31+SH:0]   prod_q;
  logic             fpz_q, sbig_q;
  logic [4:0]       s_q;

  always_ff @(posedge clk_i) begin
    if (en_a_i) begin
      a_q    <= na;
      prod_q <= (32+SH)'(nb - na) * (32+SH)'(r);
      fpz_q  <= fpz;
      sbig_q <= (s > 8'd31);
      s_q    <= s[4:0];
    end
  end

  // Stage B: interpolate, shift down, round to Q2.16
  logic [31:0] g, sh_v;
  logic [32:0] rnd;
  assign g    = fpz_q ? 32'(ONE_Q30) : (a_q + 32'(prod_q >> SH));
  assign sh_v = sbig_q ? 32'd0 : (g >> s_q);
  assign rnd  = {1'b0, sh_v} + 33'd8192;

  always_ff @(posedge clk_i) begin
    if (en_b_i) em_o <= rnd[31:14];
  end
endmodule
`default_nettype wire

@@ design/etmg_log2.sv @@
// Two-stage -log2(y/65536) unit for y in [1, 65536]: normalize and look up, then
// interpolate and subtract from the exponent. Depends on etmg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module etmg_log2 import etmg_pkg::*; #(
  parameter int unsigned TABLE_ADDR_BITS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        en_a_i,
  input  wire logic        en_b_i,
  input  wire logic [16:0] y_i,
  output logic      [34:0] n_o
);
  localparam int unsigned N  = 1 << TABLE_ADDR_BITS;
  localparam int unsigned SH = 30 - TABLE_ADDR_BITS;

  logic [30:0] tab [N+1];
  for (genvar gk = 0; gk <= N; gk++) begin : g_tab
    assign tab[gk] = log2_node(gk, TABLE_ADDR_BITS);
  end

  // Stage A: find leading one, normalize, look up neighbors
  logic [4:0]  p;
  logic [46:0] ms;
  logic [29:0] frac;
  logic [TABLE_ADDR_BITS:0] kk;
  logic [30:0] na, nb;
  logic [SH-1:0] r;

  always_comb begin
    p = 5'd0;
    for (int i = 1; i <= 16; i++) begin
      if (y_i[i]) p = 5'(i);
    end
  end

  assign ms   = 47'(y_i) << (5'd30 - p);
  assign frac = ms[29:0];
  assign kk   = {1'b0, frac[29:SH]};
  assign r    = frac[SH-1:0];
  assign na   = tab[kk];
  assign nb   = tab[kk + 1'b1];

  logic [30:0]    a_q;
  logic [30+SH:0] prod_q;
  logic [4:0]     p_q;

  always_ff @(posedge clk_i) begin
    if (en_a_i) begin
      a_q    <= na;
      prod_q <= (31+SH)'(nb - na) * (31+SH)'(r);
      p_q    <= p;
    end
  end

  // Stage B: interpolate mantissa log and negate against the exponent
  logic [30:0] lm;
  assign lm = a_q + 31'(prod_q >> SH);

  always_ff @(posedge clk_i) begin
    if (en_b_i) n_o <= (35'(5'd16 - p_q) << 30) - 35'(lm);
  end
endmodule
`default_nettype wire

@@ design/etmg_channel.sv @@
// Nine-stage datapath for one color channel: exposure, 1 - exp, log2,
// gamma scale, exp2, saturate. Depends on etmg_pkg, etmg_exp2, etmg_log2.
`timescale 1ns / 1ps
`default_nettype none
module etmg_channel import etmg_pkg::*; #(
  parameter int unsigned TABLE_ADDR_BITS = 8
) (
  input  wire logic        clk_i,
  input  wire logic [9:1]  en_i,
  input  wire logic [15:0] exposure_i,
  input  wire logic [15:0] inv_gamma_i,
  input  wire logic [31:0] v_i,
  output logic      [15:0] out_o
);
  // Stage 1: exposure product, Q24.24
  logic [47:0] x_q;
  always_ff @(posedge clk_i) begin
    if (en_i[1]) x_q <= 48'(exposure_i) * 48'(v_i);
  end

  // Stage 2: saturation test and scale by log2(e) into Q.16
  logic [59:0] tp;
  logic [EXP_TW-1:0] t_q;
  logic [4:2] sat_q;
  assign tp = 60'(x_q[27:0]) * 60'(LOG2E_Q30) + (60'd1 << 37);
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      t_q      <= EXP_TW'(tp[59:38]);
      sat_q[2] <= |x_q[47:28];
    end
    if (en_i[3]) sat_q[3] <= sat_q[2];
    if (en_i[4]) sat_q[4] <= sat_q[3];
  end

  // Stages 3-4: e = 2^-t
  logic [17:0] em1;
  etmg_exp2 #(.TABLE_ADDR_BITS(TABLE_ADDR_BITS)) u_exp_tone (
    .clk_i, .en_a_i(en_i[3]), .en_b_i(en_i[4]), .t_i(t_q), .em_o(em1)
  );

  logic [16:0] y;
  assign y = sat_q[4] ? 17'h10000 : 17'(18'h10000 - em1);

  // Stages 5-6: n = -log2(y); carry the zero mark alongside
  logic [34:0] n;
  logic [9:5]  zero_q;
  etmg_log2 #(.TABLE_ADDR_BITS(TABLE_ADDR_BITS)) u_log (
    .clk_i, .en_a_i(en_i[5]), .en_b_i(en_i[6]), .y_i(y), .n_o(n)
  );
  always_ff @(posedge clk_i) begin
    if (en_i[5]) zero_q[5] <= (y == 17'd0);
    if (en_i[6]) zero_q[6] <= zero_q[5];
    if (en_i[7]) zero_q[7] <= zero_q[6];
    if (en_i[8]) zero_q[8] <= zero_q[7];
    if (en_i[9]) zero_q[9] <= zero_q[8];
  end

  // Stage 7: scale by inverse gamma into Q.16
  logic [50:0] up;
  logic [EXP_TW-1:0] u_q;
  assign up = 51'(n) * 51'(inv_gamma_i) + (51'd1 << 27);
  always_ff @(posedge clk_i) begin
    if (en_i[7]) u_q <= up[50:28];
  end

  // Stages 8-9: 2^-u
  logic [17:0] em2;
  etmg_exp2 #(.TABLE_ADDR_BITS(TABLE_ADDR_BITS)) u_exp_gamma (
    .clk_i, .en_a_i(en_i[8]), .en_b_i(en_i[9]), .t_i(u_q), .em_o(em2)
  );

  // Saturate; force zero for a black channel
  assign out_o = zero_q[9] ? 16'd0 : ((em2 > 18'd65535) ? 16'hFFFF : em2[15:0]);
endmodule
`default_nettype wire

@@ design/etmg_checker.sv @@
// Port-level checks for the tone map top level, bound to it below.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none
module etmg_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic s_axis_tvalid,
  input wire logic s_axis_tready,
  input wire logic m_axis_tvalid,
  input wire logic m_axis_tready,
  input wire logic cfg_ready_o
);
  // A stalled result stays offered
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // No result during reset
  a_rst: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result offered in reset");

  // An empty output stage means the whole pipe can take an item
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // When the output side is ready, the input side is ready too
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output drains");

  // Configuration writes are always taken
  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("config port not ready");
endmodule

bind exposure_tone_map_gamma etmg_checker u_etmg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .cfg_ready_o   (cfg_ready_o)
);
`default_nettype wire
